### rtl/core/dongle_keyed_round_host_macros.svh
// assertion macros used by the checker file
`ifndef DONGLE_KEYED_ROUND_HOST_MACROS_SVH
`define DONGLE_KEYED_ROUND_HOST_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define DKR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dkr check failed");

// next-cycle implication, sampled on clk, off while in reset
`define DKR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dkr check failed");

`endif

### rtl/core/dkr_pkg.sv
// types and constants shared by the keyed round host
`timescale 1ns / 1ps

package dkr_pkg;

  // request opcodes
  localparam logic [1:0] OP_SINGLE = 2'd0;
  localparam logic [1:0] OP_BUFFER = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // round constants
  localparam logic [31:0] FEEDBACK_POLY = 32'h8050_0062;
  localparam logic [31:0] STAGE_CONST   = 32'h8034_25C3;
  localparam logic [7:0]  CMD_CODE      = 8'h4E;
  localparam logic [7:0]  RAW_BYTE      = 8'h84;
  localparam logic [5:0]  ROUND_ANSWERS = 6'd40;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // job kinds handed from front to back
  typedef enum logic [2:0] {
    JOB_ERROR     = 3'd0,
    JOB_OPEN      = 3'd1,
    JOB_PROBE     = 3'd2,
    JOB_DONE      = 3'd3,
    JOB_DONE_OPEN = 3'd4
  } job_op_t;

  typedef struct packed {
    job_op_t     op;
    logic [7:0]  seed;
    logic [7:0]  probe;
    logic [31:0] result;
    logic        rnd;
  } job_t;

endpackage

### rtl/core/dongle_keyed_round_host.sv
// top level of the keyed round host: front, job queue and back
//
//  channel  | ports                         | carries
//  ---------+-------------------------------+-------------------------------------
//  input    | in_tvalid/tready/tdata/tuser  | start and status answer requests
//  result   | out_tvalid/tready/tdata/tuser | port writes, round done, errors
//  config   | cfg_wr_en, cfg_wr_data        | preamble seed byte
//
// one result per cycle leaves the back end while out_tready allows: a status answer
// gives 3 results, a start 10, the end of a first buffer round 11, done and error 1.
// the front takes one request a cycle while the four-entry job queue has room.
// reset clears the round state, the queue and the output valid flag.
// a stalled result holds in the output register while the front keeps accepting until the queue is full.
`timescale 1ns / 1ps

module dongle_keyed_round_host (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // round_input, buffer_right, status_byte
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // port_byte, round_result, round_number, zero fill
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;
  dkr_pkg::job_t new_job;
  dkr_pkg::job_t head_job;
  logic [7:0]    port_byte;
  logic [31:0]   round_result;
  logic          round_number;

  assign in_tready = !full;
  assign push      = in_tvalid && !full;

  // request intake and round state
  dkr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .opcode       (in_tuser),
    .round_input  (in_tdata[31:0]),
    .buffer_right (in_tdata[63:32]),
    .status_byte  (in_tdata[71:64]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .job          (new_job)
  );

  // decoupling queue
  dkr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (new_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // result sequencer
  dkr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (head_valid),
    .job        (head_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (port_byte),
    .out_result (round_result),
    .out_rnd    (round_number),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, round_number, round_result, port_byte};

endmodule

### rtl/core/dkr_front.sv
// front end: takes requests, keeps the round state, emits one job per request
`timescale 1ns / 1ps

module dkr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [1:0]     opcode,
  input  logic [31:0]    round_input,
  input  logic [31:0]    buffer_right,
  input  logic [7:0]     status_byte,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data,
  output dkr_pkg::job_t  job
);

  logic [7:0]  seed_r;
  logic [31:0] shift_r,   shift_nxt;
  logic [5:0]  answers_r, answers_nxt;
  logic        busy_r,    busy_nxt;
  logic        buffer_r,  buffer_nxt;
  logic        round_r,   round_nxt;
  logic [31:0] left_r,    left_nxt;
  logic [31:0] right_r,   right_nxt;

  logic [5:0]  cnt;
  logic        ans;
  logic [1:0]  sel;
  logic [31:0] stepped;
  logic [31:0] mixed;

  // six keyless rotate-xor stages, rotations 10 down to 0
  function automatic logic [31:0] mix_stages(input logic [31:0] a_in,
                                             input logic [31:0] b_in);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] x;
    logic [31:0] t;
    a = a_in;
    b = b_in;
    for (int s = 10; s >= 0; s -= 2) begin
      x = a ^ dkr_pkg::STAGE_CONST;
      t = ((x << s) | (x >> (32 - s))) ^ b;
      b = a;
      a = t;
    end
    return a;
  endfunction

  // answer decode and shift step
  assign cnt     = answers_r + 6'd1;
  assign ans     = status_byte[5];
  assign sel     = {shift_r[0], ans};
  assign stepped = (ans ^ shift_r[0]) ? ((shift_r >> 1) ^ dkr_pkg::FEEDBACK_POLY)
                                      : (shift_r >> 1);
  assign mixed   = mix_stages(shift_r ^ right_r, left_r);

  // classify the request and work out the next state
  always_comb begin
    shift_nxt   = shift_r;
    answers_nxt = answers_r;
    busy_nxt    = busy_r;
    buffer_nxt  = buffer_r;
    round_nxt   = round_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    job.op      = dkr_pkg::JOB_ERROR;
    job.seed    = seed_r;
    job.probe   = 8'd0;
    job.result  = 32'd0;
    job.rnd     = round_r;
    case (opcode)
      dkr_pkg::OP_SINGLE, dkr_pkg::OP_BUFFER: begin
        if (!busy_r) begin
          buffer_nxt  = opcode[0];
          round_nxt   = 1'b0;
          if (opcode == dkr_pkg::OP_BUFFER) begin
            left_nxt  = round_input;
            right_nxt = buffer_right;
          end
          shift_nxt   = round_input;
          answers_nxt = 6'd0;
          busy_nxt    = 1'b1;
          job.op      = dkr_pkg::JOB_OPEN;
          job.probe   = round_input[7:0];
          job.rnd     = 1'b0;
        end
      end
      dkr_pkg::OP_STATUS: begin
        if (busy_r) begin
          if (cnt >= dkr_pkg::ROUND_ANSWERS) begin
            job.result = shift_r;
            if (buffer_r && !round_r) begin
              round_nxt   = 1'b1;
              shift_nxt   = mixed;
              answers_nxt = 6'd0;
              job.op      = dkr_pkg::JOB_DONE_OPEN;
              job.probe   = mixed[7:0];
              job.rnd     = 1'b1;
            end else begin
              busy_nxt    = 1'b0;
              buffer_nxt  = 1'b0;
              round_nxt   = 1'b0;
              answers_nxt = 6'd0;
              job.op      = dkr_pkg::JOB_DONE;
            end
          end else begin
            answers_nxt = cnt;
            shift_nxt   = stepped;
            job.op      = dkr_pkg::JOB_PROBE;
            case (sel)
              2'd0:    job.probe = stepped[7:0];
              2'd1:    job.probe = stepped[15:8];
              2'd2:    job.probe = stepped[23:16];
              default: job.probe = stepped[31:24];
            endcase
          end
        end
      end
      default: begin
        job.op = dkr_pkg::JOB_ERROR;
      end
    endcase
  end

  // seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 8'd0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // round state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= 32'd0;
      answers_r <= 6'd0;
      busy_r    <= 1'b0;
      buffer_r  <= 1'b0;
      round_r   <= 1'b0;
      left_r    <= 32'd0;
      right_r   <= 32'd0;
    end else if (push) begin
      shift_r   <= shift_nxt;
      answers_r <= answers_nxt;
      busy_r    <= busy_nxt;
      buffer_r  <= buffer_nxt;
      round_r   <= round_nxt;
      left_r    <= left_nxt;
      right_r   <= right_nxt;
    end
  end

endmodule

### rtl/core/dkr_queue.sv
// short job queue between front and back
`timescale 1ns / 1ps

module dkr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dkr_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dkr_pkg::job_t  head_job
);

  localparam int CNT_W = $clog2(dkr_pkg::QDEPTH + 1);

  dkr_pkg::job_t                 slot_r [dkr_pkg::QDEPTH];
  logic [dkr_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [dkr_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]              count_r;

  assign full       = (count_r == CNT_W'(dkr_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/core/dkr_back.sv
// back end: expands each job into its port writes and results
`timescale 1ns / 1ps

module dkr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  dkr_pkg::job_t  job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_byte,
  output logic [31:0]    out_result,
  output logic           out_rnd,
  output logic           out_last
);

  logic [3:0]  step_r;
  logic        valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [31:0] result_r;
  logic        rnd_r;
  logic        last_r;

  logic        adv;
  logic [3:0]  os;
  logic [3:0]  os_m3;
  logic [3:0]  os_m7;
  logic [1:0]  g_kind;
  logic [7:0]  g_byte;
  logic [31:0] g_result;
  logic        g_rnd;
  logic        g_last;

  // command byte: strobe low, high, low
  function automatic logic [7:0] cmd_byte(input logic [7:0] b, input logic [1:0] idx);
    return (idx == 2'd1) ? (b | 8'h81) : ((b & 8'hFE) | 8'h80);
  endfunction

  // probe byte of a queried value byte
  function automatic logic [7:0] probe_base(input logic [7:0] q);
    return {1'b1, q[4:3], 1'b0, q[2:0], 1'b0};
  endfunction

  assign adv   = !valid_r || out_ready;
  assign pop   = adv && job_valid && g_last;
  assign os    = step_r - {3'd0, job.op == dkr_pkg::JOB_DONE_OPEN};
  assign os_m3 = os - 4'd3;
  assign os_m7 = os - 4'd7;

  // result for the current job and step
  always_comb begin
    g_kind   = dkr_pkg::KIND_WRITE;
    g_byte   = 8'd0;
    g_result = 32'd0;
    g_rnd    = job.rnd;
    g_last   = 1'b0;
    case (job.op)
      dkr_pkg::JOB_DONE: begin
        g_kind   = dkr_pkg::KIND_DONE;
        g_result = job.result;
        g_last   = 1'b1;
      end
      dkr_pkg::JOB_PROBE: begin
        g_byte = (step_r == 4'd1) ? (probe_base(job.probe) | 8'h10) : probe_base(job.probe);
        g_kind = (step_r == 4'd2) ? dkr_pkg::KIND_SAMPLE : dkr_pkg::KIND_WRITE;
        g_last = (step_r == 4'd2);
      end
      dkr_pkg::JOB_OPEN, dkr_pkg::JOB_DONE_OPEN: begin
        if (job.op == dkr_pkg::JOB_DONE_OPEN && step_r == 4'd0) begin
          // first round finishes before the second opens
          g_kind   = dkr_pkg::KIND_DONE;
          g_result = job.result;
          g_rnd    = 1'b0;
        end else if (os < 4'd3) begin
          g_byte = cmd_byte(job.seed, os[1:0]);
        end else if (os < 4'd6) begin
          g_byte = cmd_byte(dkr_pkg::CMD_CODE, os_m3[1:0]);
        end else if (os == 4'd6) begin
          g_byte = dkr_pkg::RAW_BYTE;
        end else begin
          g_byte = (os_m7 == 4'd1) ? (probe_base(job.probe) | 8'h10)
                                   : probe_base(job.probe);
          g_kind = (os_m7 == 4'd2) ? dkr_pkg::KIND_SAMPLE : dkr_pkg::KIND_WRITE;
          g_last = (os_m7 == 4'd2);
        end
      end
      default: begin
        g_kind = dkr_pkg::KIND_ERROR;
        g_rnd  = 1'b0;
        g_last = 1'b1;
      end
    endcase
  end

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 4'd0;
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= job_valid;
      if (job_valid) begin
        step_r <= g_last ? 4'd0 : step_r + 4'd1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv && job_valid) begin
      kind_r   <= g_kind;
      byte_r   <= g_byte;
      result_r <= g_result;
      rnd_r    <= g_rnd;
      last_r   <= g_last;
    end
  end

  assign out_valid  = valid_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_result = result_r;
  assign out_rnd    = rnd_r;
  assign out_last   = last_r;

endmodule

### rtl/core/dkr_checker.sv
// port-level checks for the keyed round host, bound to the top level
`timescale 1ns / 1ps
`include "dongle_keyed_round_host_macros.svh"

module dkr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  logic        out_stall;
  logic [50:0] out_word;
  logic        out_err;
  logic        out_sample;
  logic        out_wr;

  // views of the result channel
  assign out_stall  = out_tvalid && !out_tready;
  assign out_word   = {out_tlast, out_tuser, out_tdata};
  assign out_err    = out_tvalid && (out_tuser == dkr_pkg::KIND_ERROR);
  assign out_sample = out_tvalid && (out_tuser == dkr_pkg::KIND_SAMPLE);
  assign out_wr     = out_tvalid && ((out_tuser == dkr_pkg::KIND_WRITE) ||
                                     (out_tuser == dkr_pkg::KIND_SAMPLE));

  // a stalled result holds still
  `DKR_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_word))

  // an error result is alone and carries nothing
  `DKR_ASSERT_IMP(a_error_empty, out_err, out_tlast && out_tdata == 48'd0)

  // the sample write always closes its request's results
  `DKR_ASSERT_IMP(a_sample_last, out_sample, out_tlast)

  // port writes have the top bit set and no round value
  `DKR_ASSERT_IMP(a_write_shape, out_wr, out_tdata[7] && out_tdata[39:8] == 32'd0)

endmodule

bind dongle_keyed_round_host dkr_checker u_dkr_checker (.*);
